// ===== rtl/acrs_pkg.sv =====
// ----------------------------------------------------------------------------
// acrs_pkg
// shared types and constants of the address cache refresh scheduler
// ----------------------------------------------------------------------------
package acrs_pkg;

   localparam int SLOT_COUNT_DEFAULT = 8;
   localparam int SLOT_W             = 3;
   localparam int ADDR_W             = 32;
   localparam int TICKS_W            = 16;
   localparam int OP_W               = 2;
   localparam int REQ_DATA_W         = 48;
   localparam int RSP_DATA_W         = 48;

   localparam logic [TICKS_W-1:0] REFRESH_TICKS_RESET = 16'd1500;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_SET    = 2'd1,
      OP_READ   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic                host_present;
      logic                notify_enable;
      logic                network_ready;
      logic                resolver_free;
      logic                request_accepted;
      logic                result_ready;
      logic                result_ok;
      logic [ADDR_W-1:0]   result_address;
   } req_item_type;

   typedef struct packed {
      logic                request_issued;
      logic [SLOT_W-1:0]   request_slot;
      logic                lookup_done;
      logic [SLOT_W-1:0]   done_slot;
      logic                notify;
      logic [ADDR_W-1:0]   read_address;
      logic                read_fresh;
   } rsp_item_type;

endpackage

// ===== rtl/acrs_slot_table.sv =====
// ----------------------------------------------------------------------------
// acrs_slot_table
// slot state, countdowns, expiry pick and lookup bookkeeping for one word
// ----------------------------------------------------------------------------
module acrs_slot_table #(
   parameter int SLOT_COUNT = acrs_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  acrs_pkg::req_item_type             item,
   input  logic [acrs_pkg::TICKS_W-1:0]       refresh_ticks,
   output acrs_pkg::rsp_item_type             result
);

   // slots past the 3-bit slot field can never be set, so they stay idle
   localparam int TABLE_DEPTH = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;
   localparam int TIDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                          host_ff     [TABLE_DEPTH];
   logic                          host_in     [TABLE_DEPTH];
   logic                          notify_ff   [TABLE_DEPTH];
   logic                          notify_in   [TABLE_DEPTH];
   logic [acrs_pkg::ADDR_W-1:0]   address_ff  [TABLE_DEPTH];
   logic [acrs_pkg::ADDR_W-1:0]   address_in  [TABLE_DEPTH];
   logic [acrs_pkg::TICKS_W-1:0]  count_ff    [TABLE_DEPTH];
   logic [acrs_pkg::TICKS_W-1:0]  count_in    [TABLE_DEPTH];
   logic [acrs_pkg::TICKS_W-1:0]  count_dec   [TABLE_DEPTH];
   logic                          pending_ff;
   logic                          pending_in;
   logic [TIDX_W-1:0]             pend_idx_ff;
   logic [TIDX_W-1:0]             pend_idx_in;

   logic                          have_pick;
   logic [TIDX_W-1:0]             pick_idx;
   logic                          start;
   logic                          pend_now;
   logic [TIDX_W-1:0]             idx_now;
   logic                          done;
   logic                          success;
   logic                          notify_sel;
   logic                          is_tick;

   assign is_tick = (item.op == acrs_pkg::OP_TICK);

   // decremented countdowns and highest expired slot with a host
   always_comb begin
      have_pick = 1'b0;
      pick_idx  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         count_dec[i] = (count_ff[i] != '0) ? count_ff[i] - acrs_pkg::TICKS_W'(1)
                                            : count_ff[i];
         if (count_dec[i] == '0 && host_ff[i]) begin
            have_pick = 1'b1;
            pick_idx  = TIDX_W'(i);
         end
      end
   end

   assign start    = is_tick && !pending_ff && have_pick && item.network_ready
                     && item.resolver_free && item.request_accepted;
   assign pend_now = pending_ff || start;
   assign idx_now  = start ? pick_idx : pend_idx_ff;
   assign done     = is_tick && pend_now && item.result_ready;
   assign success  = done && item.result_ok;

   always_comb begin
      notify_sel = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (TIDX_W'(i) == idx_now) begin
            notify_sel = notify_ff[i];
         end
      end
   end

   // next state of the table
   always_comb begin
      pending_in  = pending_ff;
      pend_idx_in = pend_idx_ff;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         host_in[i]    = host_ff[i];
         notify_in[i]  = notify_ff[i];
         address_in[i] = address_ff[i];
         count_in[i]   = count_ff[i];
      end
      unique case (item.op)
         acrs_pkg::OP_TICK: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               count_in[i] = count_dec[i];
               if (success && TIDX_W'(i) == idx_now) begin
                  count_in[i]   = refresh_ticks;
                  address_in[i] = item.result_address;
               end
            end
            pending_in  = pend_now && !done;
            pend_idx_in = done ? '0 : idx_now;
         end
         acrs_pkg::OP_SET: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (acrs_pkg::SLOT_W'(i) == item.slot) begin
                  host_in[i]   = item.host_present;
                  notify_in[i] = item.notify_enable;
                  count_in[i]  = '0;
               end
            end
         end
         acrs_pkg::OP_READ, acrs_pkg::OP_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   // result word
   always_comb begin
      result = '0;
      unique case (item.op)
         acrs_pkg::OP_TICK: begin
            result.request_issued = start;
            result.request_slot   = start ? acrs_pkg::SLOT_W'(pick_idx) : '0;
            result.lookup_done    = done;
            result.done_slot      = done ? acrs_pkg::SLOT_W'(idx_now) : '0;
            result.notify         = success && notify_sel;
         end
         acrs_pkg::OP_READ: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (acrs_pkg::SLOT_W'(i) == item.slot) begin
                  result.read_address = address_ff[i];
                  result.read_fresh   = (count_ff[i] != '0);
               end
            end
         end
         acrs_pkg::OP_SET, acrs_pkg::OP_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         pend_idx_ff <= '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            host_ff[i]    <= 1'b0;
            notify_ff[i]  <= 1'b0;
            address_ff[i] <= '0;
            count_ff[i]   <= '0;
         end
      end else if (step) begin
         pending_ff  <= pending_in;
         pend_idx_ff <= pend_idx_in;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            host_ff[i]    <= host_in[i];
            notify_ff[i]  <= notify_in[i];
            address_ff[i] <= address_in[i];
            count_ff[i]   <= count_in[i];
         end
      end
   end

endmodule

// ===== rtl/address_cache_refresh_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// address_cache_refresh_scheduler_top
// slot table with countdown expiry and one outstanding address lookup
// ----------------------------------------------------------------------------
//
//   channel   direction   ports                         carries
//   req_      in          tvalid tready tdata tuser     tick, set or read word
//   rsp_      out         tvalid tready tdata           one result per word
//   csr_      in          wr_en wr_data                 refresh_ticks
//
// one word enters per cycle while req_tready is high; its result passes the
// input register, then the table logic into the result register, and is on
// rsp_ from the result register
// the state update and the result are both taken at the same edge, so the
// next word always sees the table as left by the one before it
// reset clears the whole table, the pending lookup and sets refresh_ticks to 1500
// a stalled rsp_ side holds the result register and the input register, and
// req_tready drops only when both are full
//
module address_cache_refresh_scheduler_top #(
   parameter int SLOT_COUNT = acrs_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // slot, host_present, notify_enable, network_ready, resolver_free,
   // request_accepted, result_ready, result_ok, result_address, zero pad
   input  logic [acrs_pkg::REQ_DATA_W-1:0]       req_tdata,
   // op
   input  logic [acrs_pkg::OP_W-1:0]             req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // request_issued, request_slot, lookup_done, done_slot, notify,
   // read_address, read_fresh, zero pad
   output logic [acrs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [acrs_pkg::TICKS_W-1:0]          csr_wr_data
);

   logic                              req_valid_ff;
   acrs_pkg::req_item_type            req_item_ff;
   acrs_pkg::req_item_type            req_item_in;
   logic                              rsp_valid_ff;
   acrs_pkg::rsp_item_type            rsp_item_ff;
   acrs_pkg::rsp_item_type            rsp_item_in;
   logic [acrs_pkg::TICKS_W-1:0]      refresh_ff;
   logic                              advance;
   logic                              req_take;

   // input word unpacked from the stream
   always_comb begin
      req_item_in.op               = acrs_pkg::op_type'(req_tuser);
      req_item_in.slot             = req_tdata[2:0];
      req_item_in.host_present     = req_tdata[3];
      req_item_in.notify_enable    = req_tdata[4];
      req_item_in.network_ready    = req_tdata[5];
      req_item_in.resolver_free    = req_tdata[6];
      req_item_in.request_accepted = req_tdata[7];
      req_item_in.result_ready     = req_tdata[8];
      req_item_in.result_ok        = req_tdata[9];
      req_item_in.result_address   = req_tdata[41:10];
   end

   // word in the input register moves on when the result register is free
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   acrs_slot_table #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_table (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (req_item_ff),
      .refresh_ticks (refresh_ff),
      .result        (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         refresh_ff   <= acrs_pkg::REFRESH_TICKS_RESET;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            refresh_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_item_in;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[0]     = rsp_item_ff.request_issued;
      rsp_tdata[3:1]   = rsp_item_ff.request_slot;
      rsp_tdata[4]     = rsp_item_ff.lookup_done;
      rsp_tdata[7:5]   = rsp_item_ff.done_slot;
      rsp_tdata[8]     = rsp_item_ff.notify;
      rsp_tdata[40:9]  = rsp_item_ff.read_address;
      rsp_tdata[41]    = rsp_item_ff.read_fresh;
   end

endmodule

// ===== rtl/acrs_checker.sv =====
// ----------------------------------------------------------------------------
// acrs_checker
// port-level checks on the result stream of the scheduler
// ----------------------------------------------------------------------------
module acrs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [acrs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // started slot only shown with its flag
   a_req_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[3:1] == 3'd0)
      else $error("request_slot set without request_issued");

   // finished slot only shown with its flag
   a_done_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[7:5] == 3'd0)
      else $error("done_slot set without lookup_done");

   // notification only when a lookup finishes
   a_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[4])
      else $error("notify without lookup_done");

   // no result straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

endmodule

bind address_cache_refresh_scheduler_top acrs_checker u_acrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/tb_address_cache_refresh_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// tb_address_cache_refresh_scheduler_top
// self-checking bench for the address cache refresh scheduler: a queue-fed
// driver offers tick, set and read words, an in-bench slot table predicts
// every result word, and a monitor compares results field by field under
// random idling on both sides and under several refresh settings
// ----------------------------------------------------------------------------
module tb_address_cache_refresh_scheduler_top;

   localparam int CYCLE_LIMIT = 300000;

   // clock and reset, every input known from time zero
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // slot, host_present, notify_enable, network_ready, resolver_free,
   // request_accepted, result_ready, result_ok, result_address, zero pad
   logic [acrs_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   // op
   logic [acrs_pkg::OP_W-1:0]         req_tuser = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // request_issued, request_slot, lookup_done, done_slot, notify,
   // read_address, read_fresh, zero pad
   logic [acrs_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_wr_en = 1'b0;
   logic [acrs_pkg::TICKS_W-1:0]      csr_wr_data = '0;

   address_cache_refresh_scheduler_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // words waiting to be offered, and result words still owed by the block
   acrs_pkg::req_item_type  word_queue[$];
   acrs_pkg::rsp_item_type  expected_results[$];
   acrs_pkg::req_item_type  offered;

   int            send_idle_pct = 30;
   int            recv_idle_pct = 66;
   int            words_in      = 0;
   int            words_popped  = 0;
   int            words_checked = 0;
   int            fail_count    = 0;
   int            cycle_count   = 0;

   // shadow copy of the slot table and the lookup in flight
   logic                           host_shadow   [acrs_pkg::SLOT_COUNT_DEFAULT];
   logic                           notify_shadow [acrs_pkg::SLOT_COUNT_DEFAULT];
   logic [acrs_pkg::ADDR_W-1:0]    addr_shadow   [acrs_pkg::SLOT_COUNT_DEFAULT];
   logic [acrs_pkg::TICKS_W-1:0]   count_shadow  [acrs_pkg::SLOT_COUNT_DEFAULT];
   logic                           lookup_pending = 1'b0;
   logic [acrs_pkg::SLOT_W-1:0]    lookup_slot    = '0;
   logic [acrs_pkg::TICKS_W-1:0]   refresh_shadow = acrs_pkg::REFRESH_TICKS_RESET;

   initial begin
      for (int i = 0; i < acrs_pkg::SLOT_COUNT_DEFAULT; i++) begin
         host_shadow[i]   = 1'b0;
         notify_shadow[i] = 1'b0;
         addr_shadow[i]   = '0;
         count_shadow[i]  = '0;
      end
   end

   // advance the shadow table by one word and return the result it owes
   function automatic acrs_pkg::rsp_item_type schedule_step(acrs_pkg::req_item_type w);
      acrs_pkg::rsp_item_type      r;
      logic                        have_pick;
      logic [acrs_pkg::SLOT_W-1:0] pick;
      r         = '0;
      have_pick = 1'b0;
      pick      = '0;
      case (w.op)
         acrs_pkg::OP_TICK: begin
            // count down, then the highest expired slot with a host wins
            for (int i = 0; i < acrs_pkg::SLOT_COUNT_DEFAULT; i++) begin
               if (count_shadow[i] != '0)
                  count_shadow[i] = count_shadow[i] - acrs_pkg::TICKS_W'(1);
               if (count_shadow[i] == '0 && host_shadow[i]) begin
                  have_pick = 1'b1;
                  pick      = acrs_pkg::SLOT_W'(i);
               end
            end
            if (!lookup_pending && have_pick && w.network_ready && w.resolver_free
                && w.request_accepted) begin
               lookup_pending   = 1'b1;
               lookup_slot      = pick;
               r.request_issued = 1'b1;
               r.request_slot   = pick;
            end
            // a result may close a lookup opened on this very tick
            if (lookup_pending && w.result_ready) begin
               r.lookup_done = 1'b1;
               r.done_slot   = lookup_slot;
               if (w.result_ok) begin
                  addr_shadow[lookup_slot]  = w.result_address;
                  count_shadow[lookup_slot] = refresh_shadow;
                  r.notify                  = notify_shadow[lookup_slot];
               end
               lookup_pending = 1'b0;
               lookup_slot    = '0;
            end
         end
         acrs_pkg::OP_SET: begin
            host_shadow[w.slot]   = w.host_present;
            notify_shadow[w.slot] = w.notify_enable;
            count_shadow[w.slot]  = '0;
         end
         acrs_pkg::OP_READ: begin
            r.read_address = addr_shadow[w.slot];
            r.read_fresh   = (count_shadow[w.slot] != '0);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic queue_word(acrs_pkg::op_type op, int slot, bit hp, bit ne, bit nr,
                             bit rf, bit ra, bit rr, bit ro,
                             logic [acrs_pkg::ADDR_W-1:0] addr);
      acrs_pkg::req_item_type w;
      w.op               = op;
      w.slot             = acrs_pkg::SLOT_W'(slot);
      w.host_present     = hp;
      w.notify_enable    = ne;
      w.network_ready    = nr;
      w.resolver_free    = rf;
      w.request_accepted = ra;
      w.result_ready     = rr;
      w.result_ok        = ro;
      w.result_address   = addr;
      word_queue.push_back(w);
   endtask

   // mostly ticks that can start and finish lookups, with sets to re-arm
   // slots, reads to observe them, and a sprinkle of unused ops as noise
   task automatic queue_random_words(int n);
      acrs_pkg::req_item_type w;
      logic [63:0]            raw;
      int                     r;
      for (int k = 0; k < n; k++) begin
         raw = {$urandom, $urandom};
         w   = raw[$bits(acrs_pkg::req_item_type)-1:0];
         r   = $urandom_range(99);
         if (r < 58)
            w.op = acrs_pkg::OP_TICK;
         else if (r < 73)
            w.op = acrs_pkg::OP_SET;
         else if (r < 95)
            w.op = acrs_pkg::OP_READ;
         else
            w.op = acrs_pkg::OP_UNUSED;
         if (w.op == acrs_pkg::OP_TICK) begin
            w.network_ready    = ($urandom_range(99) < 85);
            w.resolver_free    = ($urandom_range(99) < 85);
            w.request_accepted = ($urandom_range(99) < 85);
            w.result_ready     = ($urandom_range(99) < 50);
            w.result_ok        = ($urandom_range(99) < 75);
            r = $urandom_range(19);
            if (r == 0)
               w.result_address = '0;
            else if (r == 1)
               w.result_address = '1;
         end
         if (w.op == acrs_pkg::OP_SET)
            w.host_present = ($urandom_range(99) < 80);
         word_queue.push_back(w);
      end
   endtask

   // block idle: nothing queued, every word taken from the queue checked
   task automatic drain();
      while (word_queue.size() != 0 || words_popped != words_checked
             || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_refresh(logic [acrs_pkg::TICKS_W-1:0] value);
      drain();
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= value;
      refresh_shadow  = value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
   endtask

   // driver: offers the next queued word, with random idling, once the current one is taken
   always @(posedge clock) begin : driver
      acrs_pkg::req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(schedule_step(offered));
            words_in <= words_in + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = word_queue.pop_front();
               words_popped++;
               offered    <= nxt;
               req_tuser  <= nxt.op;
               req_tdata  <= {6'b0, nxt.result_address, nxt.result_ok, nxt.result_ready,
                              nxt.request_accepted, nxt.resolver_free, nxt.network_ready,
                              nxt.notify_enable, nxt.host_present, nxt.slot};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off so that the
   // result and input registers fill and req_tready has to drop
   int  stall_left = 0;
   bit  long_stall_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!long_stall_done && words_in >= 400) begin
         rsp_tready      <= 1'b0;
         stall_left      <= 250;
         long_stall_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(string name, logic [acrs_pkg::ADDR_W-1:0] want,
                              logic [acrs_pkg::ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // monitor: each result word against the oldest prediction
   always @(posedge clock) begin : monitor
      acrs_pkg::rsp_item_type got;
      acrs_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.request_issued = rsp_tdata[0];
         got.request_slot   = rsp_tdata[3:1];
         got.lookup_done    = rsp_tdata[4];
         got.done_slot      = rsp_tdata[7:5];
         got.notify         = rsp_tdata[8];
         got.read_address   = rsp_tdata[40:9];
         got.read_fresh     = rsp_tdata[41];
         if (expected_results.size() == 0) begin
            $error("result word with no prediction waiting: %0h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("request_issued", acrs_pkg::ADDR_W'(want.request_issued),
                        acrs_pkg::ADDR_W'(got.request_issued));
            check_field("request_slot",   acrs_pkg::ADDR_W'(want.request_slot),
                        acrs_pkg::ADDR_W'(got.request_slot));
            check_field("lookup_done",    acrs_pkg::ADDR_W'(want.lookup_done),
                        acrs_pkg::ADDR_W'(got.lookup_done));
            check_field("done_slot",      acrs_pkg::ADDR_W'(want.done_slot),
                        acrs_pkg::ADDR_W'(got.done_slot));
            check_field("notify",         acrs_pkg::ADDR_W'(want.notify),
                        acrs_pkg::ADDR_W'(got.notify));
            check_field("read_address",   want.read_address, got.read_address);
            check_field("read_fresh",     acrs_pkg::ADDR_W'(want.read_fresh),
                        acrs_pkg::ADDR_W'(got.read_fresh));
         end
         words_checked++;
      end
   end

   // watchdog, generous against the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset refresh of 1500
      // empty table reads zero, unused op gives an all-zero result
      queue_word(acrs_pkg::OP_READ,   0, 0, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_UNUSED, 7, 1, 1, 1, 1, 1, 1, 1, '1);
      // result with nothing pending and nothing to pick
      queue_word(acrs_pkg::OP_TICK,   7, 1, 1, 1, 1, 1, 1, 1, '1);
      queue_word(acrs_pkg::OP_SET,    7, 1, 1, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_SET,    3, 1, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_SET,    0, 0, 1, 0, 0, 0, 0, 0, '0);
      // each start condition missing in turn
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 0, 1, 1, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 0, 1, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 0, 0, 0, '0);
      // start and finish on one tick, highest slot, notify on
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 1, 1, '1);
      queue_word(acrs_pkg::OP_READ,   7, 0, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 0, 0, '0);
      // failed lookup while one is pending: no new start, slot stays expired
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 1, 0, 32'h1234_5678);
      queue_word(acrs_pkg::OP_READ,   3, 0, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 1, 1, '0);
      queue_word(acrs_pkg::OP_READ,   3, 0, 0, 0, 0, 0, 0, 0, '0);
      // a set clears the countdown but keeps the address
      queue_word(acrs_pkg::OP_SET,    7, 1, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_READ,   7, 0, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 1, 1, 32'hA5A5_5A5A);
      queue_word(acrs_pkg::OP_SET,    0, 0, 0, 0, 0, 0, 0, 0, '0);

      // zero refresh: a refreshed slot stays expired and is asked for again
      write_refresh('0);
      queue_word(acrs_pkg::OP_SET,    5, 1, 1, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 1, 1, 32'h0A00_0001);
      queue_word(acrs_pkg::OP_READ,   5, 0, 0, 0, 0, 0, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 0, 0, '0);
      queue_word(acrs_pkg::OP_TICK,   0, 0, 0, 1, 1, 1, 1, 1, 32'h0A00_0002);

      // sender idles lightly, receiver heavily
      send_idle_pct = 30;
      recv_idle_pct = 66;
      queue_random_words(250);
      write_refresh(16'd1);
      queue_random_words(300);

      // the other way round
      write_refresh('1);
      send_idle_pct = 66;
      recv_idle_pct = 30;
      queue_random_words(250);

      // short refresh periods keep slots expiring; last phases run flat out
      for (int k = 0; k < 5; k++) begin
         write_refresh(acrs_pkg::TICKS_W'($urandom_range(2, 40)));
         if (k >= 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random_words(220);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
